### src/solid_fraction_and_drag_update_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the solid fraction and drag update block
// Shorthand for clocked properties on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SOLID_FRACTION_AND_DRAG_UPDATE_MACROS_SVH
`define SOLID_FRACTION_AND_DRAG_UPDATE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define SFDU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SFDU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sfdu_pkg.sv
// ----------------------------------------------------------------------------
// sfdu_pkg
// Shared constants, register indexes and sequencer states of the solid
// fraction and drag update block.
// ----------------------------------------------------------------------------
package sfdu_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS      = 15;
    localparam int TEMP_FRAC_BITS = 4;
    localparam int DV_SHIFT       = FRAC_BITS + TEMP_FRAC_BITS;

    localparam logic [15:0] FRAC_ONE = 16'(1 << FRAC_BITS);

    // Stream payload widths (whole bytes)
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 112;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LATENT_HEAT   = 3'd0,
        REG_LIQUIDUS_TEMP = 3'd1,
        REG_SOLIDUS_TEMP  = 3'd2,
        REG_RELAX_FACTOR  = 3'd3,
        REG_DRAG_CONSTANT = 3'd4,
        REG_DRAG_OFFSET   = 3'd5
    } sfdu_reg_t;

    // Register reset values
    localparam logic [23:0] LATENT_HEAT_RST   = 24'd270000;
    localparam logic [19:0] LIQUIDUS_TEMP_RST = 20'd28800;
    localparam logic [19:0] SOLIDUS_TEMP_RST  = 20'd27200;
    localparam logic [15:0] RELAX_FACTOR_RST  = 16'd32768;
    localparam logic [31:0] DRAG_CONSTANT_RST = 32'd100000;
    localparam logic [15:0] DRAG_OFFSET_RST   = 16'd66;

    // Shared divider remainder and iteration counter widths, accumulator width
    localparam int REM_W = 49;
    localparam int ACC_W = 113;
    localparam int CNT_W = 7;

    // Quotient bits produced per division
    localparam logic [CNT_W-1:0] LEVER_QBITS = 7'd15;
    localparam logic [CNT_W-1:0] STEP_QBITS  = 7'd17;
    localparam logic [CNT_W-1:0] DRAG_QBITS  = 7'd64;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_R1,
        ST_R2,
        ST_R3,
        ST_R4,
        ST_RCHK,
        ST_DIV,
        ST_FRAC,
        ST_D0,
        ST_D1,
        ST_D2,
        ST_D3,
        ST_D4,
        ST_D5,
        ST_D6,
        ST_D7,
        ST_D8,
        ST_D9,
        ST_D10,
        ST_DCHK,
        ST_OUT
    } sfdu_state_t;

endpackage

### src/solid_fraction_and_drag_update.sv
// ----------------------------------------------------------------------------
// solid_fraction_and_drag_update
// Per-cell solid fraction update (lever rule or relaxed latent heat), phase
// weighting, Carman-Kozeny drag coefficient and sweep residual tracking.
// ----------------------------------------------------------------------------
// Input is not ready while a cell is in work; the next cell is taken once the
// result of the last one is loaded into the output register. The drag quotient
// of 64 bits on the shared 1-bit-per-cycle divider is the longest step when it runs.
// Reset: asynchronous, active low; registers take their default values and
// the sweep residual clears to zero.
// ----------------------------------------------------------------------------
module solid_fraction_and_drag_update
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // temperature[19:0], old_solid_fraction[35:20], heat_capacity[51:36],
    // phase_fraction[67:52], cell_volume[99:68], zero pad[103:100]
    input  logic [sfdu_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // mode[0]
    input  logic                                  s_axis_tuser,
    input  logic                                  s_axis_tlast,
    // Output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // new_solid_fraction[15:0], weighted_solid_fraction[31:16],
    // drag_coefficient[95:32], sweep_residual[111:96]
    output logic [sfdu_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tlast,
    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sfdu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sfdu_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    sfdu_pkg::sfdu_state_t state_reg, state_next;

    // Configuration registers
    logic [23:0] latent_heat_reg;
    logic [19:0] liquidus_temp_reg;
    logic [19:0] solidus_temp_reg;
    logic [15:0] relax_factor_reg;
    logic [31:0] drag_constant_reg;
    logic [15:0] drag_offset_reg;

    // Captured cell
    logic        mode_reg;
    logic [19:0] temp_reg;
    logic [15:0] old_reg;
    logic [15:0] cp_reg;
    logic [15:0] phase_reg;
    logic [31:0] vol_reg;
    logic        last_reg;

    // Working registers
    logic [15:0]                  sf_reg, sf_next;
    logic [15:0]                  s_reg, s_next;
    logic [35:0]                  mag_reg, mag_next;
    logic                         neg_reg, neg_next;
    logic [31:0]                  rc_reg, rc_next;
    logic [sfdu_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [48:0]                  den_reg, den_next;
    logic [48:0]                  s2_reg, s2_next;
    logic [63:0]                  vc_reg, vc_next;
    logic [sfdu_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [sfdu_pkg::REM_W-1:0]   dvs_reg, dvs_next;
    logic [63:0]                  low_reg, low_next;
    logic [63:0]                  quo_reg, quo_next;
    logic [sfdu_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         div_drag_reg, div_drag_next;
    logic                         sat_reg, sat_next;
    logic                         drag_sat_reg, drag_sat_next;
    logic [15:0]                  res_out_reg, res_out_next;
    logic [15:0]                  resid_reg, resid_next;

    // Shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_reg;

    // Output register
    logic                               m_valid_reg, m_valid_next;
    logic [sfdu_pkg::OUT_TDATA_W-1:0]   m_data_reg, m_data_next;
    logic                               m_last_reg, m_last_next;

    // Combinational helpers
    logic [15:0]        old_in, phase_in;
    logic signed [20:0] gap_raw, num;
    logic [19:0]        gap_eff;
    logic               num_le_zero, num_ge_gap;
    logic signed [36:0] num_sh, inner;
    logic [36:0]        inner_abs;
    logic [23:0]        lh_eff;
    logic [42:0]        dv;
    logic [15:0]        q_eff;
    logic [15:0]        u;
    logic [49:0]        div_trial;
    logic               div_ge;
    logic [17:0]        step;
    logic [17:0]        step_sum;
    logic [15:0]        diff;
    logic [15:0]        resid_max;
    logic               out_free;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign s_axis_tready = (state_reg == sfdu_pkg::ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latent_heat_reg   <= sfdu_pkg::LATENT_HEAT_RST;
            liquidus_temp_reg <= sfdu_pkg::LIQUIDUS_TEMP_RST;
            solidus_temp_reg  <= sfdu_pkg::SOLIDUS_TEMP_RST;
            relax_factor_reg  <= sfdu_pkg::RELAX_FACTOR_RST;
            drag_constant_reg <= sfdu_pkg::DRAG_CONSTANT_RST;
            drag_offset_reg   <= sfdu_pkg::DRAG_OFFSET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (sfdu_pkg::sfdu_reg_t'(cfg_index))
                sfdu_pkg::REG_LATENT_HEAT:   latent_heat_reg   <= cfg_data[23:0];
                sfdu_pkg::REG_LIQUIDUS_TEMP: liquidus_temp_reg <= cfg_data[19:0];
                sfdu_pkg::REG_SOLIDUS_TEMP:  solidus_temp_reg  <= cfg_data[19:0];
                sfdu_pkg::REG_RELAX_FACTOR:  relax_factor_reg  <= cfg_data[15:0];
                sfdu_pkg::REG_DRAG_CONSTANT: drag_constant_reg <= cfg_data[31:0];
                sfdu_pkg::REG_DRAG_OFFSET:   drag_offset_reg   <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input capture, fractions above one saturate to one
    // ------------------------------------------------------------------
    assign old_in   = (s_axis_tdata[35:20] > sfdu_pkg::FRAC_ONE) ? sfdu_pkg::FRAC_ONE
                                                                  : s_axis_tdata[35:20];
    assign phase_in = (s_axis_tdata[67:52] > sfdu_pkg::FRAC_ONE) ? sfdu_pkg::FRAC_ONE
                                                                  : s_axis_tdata[67:52];

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            mode_reg  <= s_axis_tuser;
            temp_reg  <= s_axis_tdata[19:0];
            old_reg   <= old_in;
            cp_reg    <= s_axis_tdata[51:36];
            phase_reg <= phase_in;
            vol_reg   <= s_axis_tdata[99:68];
            last_reg  <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Temperature terms and operand conditioning
    // ------------------------------------------------------------------
    assign gap_raw     = $signed({1'b0, liquidus_temp_reg}) - $signed({1'b0, solidus_temp_reg});
    assign gap_eff     = (gap_raw[20] || (gap_raw == 21'sd0)) ? 20'd1 : gap_raw[19:0];
    assign num         = $signed({1'b0, liquidus_temp_reg}) - $signed({1'b0, temp_reg});
    assign num_le_zero = num[20] || (num == 21'sd0);
    assign num_ge_gap  = !num[20] && (num[19:0] >= gap_eff);

    // inner = num * ONE - old * gap, old * gap comes from the multiplier
    assign num_sh    = {num[20], num, 15'd0};
    assign inner     = num_sh - $signed({2'b00, prod_reg[34:0]});
    assign inner_abs = inner[36] ? 37'(-inner) : 37'(inner);

    assign lh_eff = (latent_heat_reg == 24'd0) ? 24'd1 : latent_heat_reg;
    assign dv     = {lh_eff, 19'd0};
    assign q_eff  = (drag_offset_reg == 16'd0) ? 16'd1 : drag_offset_reg;
    assign u      = sfdu_pkg::FRAC_ONE - s_reg;

    // Shared restoring divider step
    assign div_trial = {rem_reg, low_reg[63]};
    assign div_ge    = (div_trial >= {1'b0, dvs_reg});

    // Relaxed step, anything at or beyond 2^17 clamps either way
    assign step     = sat_reg ? 18'h20000 : {1'b0, quo_reg[16:0]};
    assign step_sum = {2'b00, old_reg} + step;

    // Absolute change and running maximum
    assign diff      = (old_reg >= sf_reg) ? (old_reg - sf_reg) : (sf_reg - old_reg);
    assign resid_max = (diff > resid_reg) ? diff : resid_reg;

    // ------------------------------------------------------------------
    // Shared 32x32 multiplier, product registered
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            sfdu_pkg::ST_START:
            begin
                mul_a = {16'd0, old_reg};
                mul_b = {12'd0, gap_eff};
            end
            sfdu_pkg::ST_R1:
            begin
                mul_a = {16'd0, relax_factor_reg};
                mul_b = {16'd0, cp_reg};
            end
            sfdu_pkg::ST_R2:
            begin
                mul_a = prod_reg[31:0];
                mul_b = mag_reg[31:0];
            end
            sfdu_pkg::ST_R3:
            begin
                mul_a = rc_reg;
                mul_b = {28'd0, mag_reg[35:32]};
            end
            sfdu_pkg::ST_D0:
            begin
                mul_a = {16'd0, phase_reg};
                mul_b = {16'd0, sf_reg};
            end
            sfdu_pkg::ST_D2:
            begin
                mul_a = {16'd0, u};
                mul_b = {16'd0, u};
            end
            sfdu_pkg::ST_D3:
            begin
                mul_a = prod_reg[31:0];
                mul_b = {16'd0, u};
            end
            sfdu_pkg::ST_D4:
            begin
                mul_a = {16'd0, s_reg};
                mul_b = {16'd0, s_reg};
            end
            sfdu_pkg::ST_D5:
            begin
                mul_a = vol_reg;
                mul_b = drag_constant_reg;
            end
            sfdu_pkg::ST_D6:
            begin
                mul_a = prod_reg[31:0];
                mul_b = s2_reg[31:0];
            end
            sfdu_pkg::ST_D7:
            begin
                mul_a = vc_reg[31:0];
                mul_b = {15'd0, s2_reg[48:32]};
            end
            sfdu_pkg::ST_D8:
            begin
                mul_a = vc_reg[63:32];
                mul_b = s2_reg[31:0];
            end
            sfdu_pkg::ST_D9:
            begin
                mul_a = vc_reg[63:32];
                mul_b = {15'd0, s2_reg[48:32]};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // ------------------------------------------------------------------
    // Sequencer next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfdu_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = sfdu_pkg::ST_START;
                end
            end
            sfdu_pkg::ST_START:
            begin
                if (mode_reg)
                begin
                    state_next = sfdu_pkg::ST_R1;
                end
                else if (num_le_zero || num_ge_gap)
                begin
                    state_next = sfdu_pkg::ST_D0;
                end
                else
                begin
                    state_next = sfdu_pkg::ST_DIV;
                end
            end
            sfdu_pkg::ST_R1:   state_next = sfdu_pkg::ST_R2;
            sfdu_pkg::ST_R2:   state_next = sfdu_pkg::ST_R3;
            sfdu_pkg::ST_R3:   state_next = sfdu_pkg::ST_R4;
            sfdu_pkg::ST_R4:   state_next = sfdu_pkg::ST_RCHK;
            sfdu_pkg::ST_RCHK:
            begin
                if (acc_reg[67:17] >= {8'd0, dv})
                begin
                    state_next = sfdu_pkg::ST_FRAC;
                end
                else
                begin
                    state_next = sfdu_pkg::ST_DIV;
                end
            end
            sfdu_pkg::ST_DIV:
            begin
                if (cnt_reg == sfdu_pkg::CNT_W'(1))
                begin
                    state_next = div_drag_reg ? sfdu_pkg::ST_OUT : sfdu_pkg::ST_FRAC;
                end
            end
            sfdu_pkg::ST_FRAC: state_next = sfdu_pkg::ST_D0;
            sfdu_pkg::ST_D0:   state_next = sfdu_pkg::ST_D1;
            sfdu_pkg::ST_D1:   state_next = sfdu_pkg::ST_D2;
            sfdu_pkg::ST_D2:   state_next = sfdu_pkg::ST_D3;
            sfdu_pkg::ST_D3:   state_next = sfdu_pkg::ST_D4;
            sfdu_pkg::ST_D4:   state_next = sfdu_pkg::ST_D5;
            sfdu_pkg::ST_D5:   state_next = sfdu_pkg::ST_D6;
            sfdu_pkg::ST_D6:   state_next = sfdu_pkg::ST_D7;
            sfdu_pkg::ST_D7:   state_next = sfdu_pkg::ST_D8;
            sfdu_pkg::ST_D8:   state_next = sfdu_pkg::ST_D9;
            sfdu_pkg::ST_D9:   state_next = sfdu_pkg::ST_D10;
            sfdu_pkg::ST_D10:  state_next = sfdu_pkg::ST_DCHK;
            sfdu_pkg::ST_DCHK:
            begin
                if (acc_reg[112:64] >= den_reg)
                begin
                    state_next = sfdu_pkg::ST_OUT;
                end
                else
                begin
                    state_next = sfdu_pkg::ST_DIV;
                end
            end
            sfdu_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = sfdu_pkg::ST_IDLE;
                end
            end
            default:           state_next = sfdu_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: datapath register updates
    // ------------------------------------------------------------------
    always_comb
    begin
        sf_next       = sf_reg;
        s_next        = s_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        rc_next       = rc_reg;
        acc_next      = acc_reg;
        den_next      = den_reg;
        s2_next       = s2_reg;
        vc_next       = vc_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        low_next      = low_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        div_drag_next = div_drag_reg;
        sat_next      = sat_reg;
        drag_sat_next = drag_sat_reg;
        res_out_next  = res_out_reg;
        resid_next    = resid_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;

        // Drop the result once the downstream side takes it
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            sfdu_pkg::ST_START:
            begin
                sat_next      = 1'b0;
                div_drag_next = 1'b0;
                quo_next      = '0;
                if (num_le_zero)
                begin
                    sf_next = 16'd0;
                end
                else if (num_ge_gap)
                begin
                    sf_next = sfdu_pkg::FRAC_ONE;
                end
                else
                begin
                    // Lever rule quotient (num << 15) / gap, num below gap
                    rem_next = {29'd0, num[19:0]};
                    low_next = '0;
                    dvs_next = {29'd0, gap_eff};
                    cnt_next = sfdu_pkg::LEVER_QBITS;
                end
            end
            sfdu_pkg::ST_R1:
            begin
                neg_next = inner[36];
                mag_next = inner_abs[35:0];
            end
            sfdu_pkg::ST_R2:
            begin
                rc_next = prod_reg[31:0];
            end
            sfdu_pkg::ST_R3:
            begin
                acc_next = {49'd0, prod_reg};
            end
            sfdu_pkg::ST_R4:
            begin
                acc_next = acc_reg + {17'd0, prod_reg, 32'd0};
            end
            sfdu_pkg::ST_RCHK:
            begin
                if (acc_reg[67:17] >= {8'd0, dv})
                begin
                    sat_next = 1'b1;
                end
                else
                begin
                    rem_next = acc_reg[65:17];
                    low_next = {acc_reg[16:0], 47'd0};
                    dvs_next = {6'd0, dv};
                    cnt_next = sfdu_pkg::STEP_QBITS;
                end
            end
            sfdu_pkg::ST_DIV:
            begin
                rem_next = div_ge ? sfdu_pkg::REM_W'(div_trial - {1'b0, dvs_reg})
                                  : div_trial[sfdu_pkg::REM_W-1:0];
                low_next = {low_reg[62:0], 1'b0};
                quo_next = {quo_reg[62:0], div_ge};
                cnt_next = cnt_reg - sfdu_pkg::CNT_W'(1);
            end
            sfdu_pkg::ST_FRAC:
            begin
                if (!mode_reg)
                begin
                    sf_next = quo_reg[15:0];
                end
                else if (neg_reg)
                begin
                    sf_next = (step > {2'b00, old_reg}) ? 16'd0 : 16'(old_reg - step[15:0]);
                end
                else
                begin
                    sf_next = (step_sum > {2'b00, sfdu_pkg::FRAC_ONE}) ? sfdu_pkg::FRAC_ONE
                                                                      : step_sum[15:0];
                end
            end
            sfdu_pkg::ST_D0:
            begin
                // Track the sweep maximum, clear it after the last cell
                res_out_next = resid_max;
                resid_next   = last_reg ? 16'd0 : resid_max;
            end
            sfdu_pkg::ST_D1:
            begin
                s_next = prod_reg[2*sfdu_pkg::FRAC_BITS:sfdu_pkg::FRAC_BITS];
            end
            sfdu_pkg::ST_D4:
            begin
                // (1 - s)^3 in Q.48 plus offset q in Q.48
                den_next = {prod_reg[45:0], 3'd0} + {1'b0, q_eff, 32'd0};
            end
            sfdu_pkg::ST_D5:
            begin
                s2_next = {prod_reg[30:0], 18'd0};
            end
            sfdu_pkg::ST_D6:
            begin
                vc_next = prod_reg;
            end
            sfdu_pkg::ST_D7:
            begin
                acc_next = {49'd0, prod_reg};
            end
            sfdu_pkg::ST_D8, sfdu_pkg::ST_D9:
            begin
                acc_next = acc_reg + {17'd0, prod_reg, 32'd0};
            end
            sfdu_pkg::ST_D10:
            begin
                acc_next = acc_reg + {prod_reg[48:0], 64'd0};
            end
            sfdu_pkg::ST_DCHK:
            begin
                div_drag_next = 1'b1;
                quo_next      = '0;
                if (acc_reg[112:64] >= den_reg)
                begin
                    drag_sat_next = 1'b1;
                end
                else
                begin
                    drag_sat_next = 1'b0;
                    rem_next      = acc_reg[112:64];
                    low_next      = acc_reg[63:0];
                    dvs_next      = den_reg;
                    cnt_next      = sfdu_pkg::DRAG_QBITS;
                end
            end
            sfdu_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_last_next  = last_reg;
                    m_data_next  = {res_out_reg,
                                    (drag_sat_reg ? {64{1'b1}} : quo_reg),
                                    s_reg,
                                    sf_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sfdu_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            resid_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            resid_reg   <= resid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        sf_reg       <= sf_next;
        s_reg        <= s_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        rc_reg       <= rc_next;
        acc_reg      <= acc_next;
        den_reg      <= den_next;
        s2_reg       <= s2_next;
        vc_reg       <= vc_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        low_reg      <= low_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        div_drag_reg <= div_drag_next;
        sat_reg      <= sat_next;
        drag_sat_reg <= drag_sat_next;
        res_out_reg  <= res_out_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

endmodule

### src/sfdu_checker.sv
// ----------------------------------------------------------------------------
// sfdu_checker
// Port-level assertions for the solid fraction and drag update block,
// bound to the top level.
// ----------------------------------------------------------------------------
`include "solid_fraction_and_drag_update_macros.svh"

module sfdu_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [sfdu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input logic                                 m_axis_tlast
);

    // Hold off further input while a cell is in work
    `SFDU_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while busy")

    // Hold a stalled result
    `SFDU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

    // New fraction and sweep residual stay within one
    `SFDU_ASSERT_SAME(a_frac_range, m_axis_tvalid, (m_axis_tdata[15:0] <= sfdu_pkg::FRAC_ONE) && (m_axis_tdata[111:96] <= sfdu_pkg::FRAC_ONE), "fraction above one")

    // Phase weighting never raises the fraction
    `SFDU_ASSERT_SAME(a_weighted_le_new, m_axis_tvalid, m_axis_tdata[31:16] <= m_axis_tdata[15:0], "weighted fraction above new fraction")

endmodule

bind solid_fraction_and_drag_update sfdu_checker u_sfdu_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
